### rtl/tdtm_pkg.sv
// tdtm_pkg: shared types and constants for the task delay tick manager
// holds the per-task slot layout and the opcode values; no dependencies
`default_nettype none

package tdtm_pkg;

  localparam int COUNT_W   = 16;
  localparam int TASK_ID_W = 3;
  localparam int MASK_W    = 8;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_SLEEP = 1'b1;

  // one task's state as it travels around the ring
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               ready;
  } tdtm_slot_t;

endpackage

`default_nettype wire

### rtl/tdtm_cell.sv
// tdtm_cell: one stage of the task ring, holds a single task slot
// depends on tdtm_pkg for the slot type
`default_nettype none

module tdtm_cell (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                shift,
  input  wire tdtm_pkg::tdtm_slot_t slot_in,
  output tdtm_pkg::tdtm_slot_t     slot_out
);

  tdtm_pkg::tdtm_slot_t slot;

  // a task starts out ready with no delay pending
  always_ff @(posedge clk) begin
    if (rst) begin
      slot.count <= '0;
      slot.ready <= 1'b1;
    end else if (shift) begin
      slot <= slot_in;
    end
  end

  assign slot_out = slot;

endmodule

`default_nettype wire

### rtl/tdtm_update.sv
// tdtm_update: applies a tick or a sleep to the slot leaving the ring head
// depends on tdtm_pkg for the slot type and opcodes
`default_nettype none

module tdtm_update (
  input  wire logic                              op,
  input  wire logic                              hit,
  input  wire logic [tdtm_pkg::COUNT_W-1:0]      ticks,
  input  wire tdtm_pkg::tdtm_slot_t              slot_in,
  output tdtm_pkg::tdtm_slot_t                   slot_out
);

  always_comb begin
    slot_out = slot_in;
    unique case (op)
      tdtm_pkg::OP_SLEEP: begin
        if (hit && (ticks != '0)) begin
          slot_out.count = ticks;
          slot_out.ready = 1'b0;
        end
      end
      default: begin
        if (slot_in.count != '0) begin
          slot_out.count = slot_in.count - tdtm_pkg::COUNT_W'(1);
          // counter runs out on this tick
          if (slot_in.count == tdtm_pkg::COUNT_W'(1)) begin
            slot_out.ready = 1'b1;
          end
        end
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/task_delay_tick_manager_core.sv
// task_delay_tick_manager_core: top level, ring of task cells plus update unit
// depends on tdtm_pkg, tdtm_cell and tdtm_update
//
//   channel | signals                               | dir | word
//   in      | in_valid in_ready opcode task_id       | in  | tick or sleep request
//           | sleep_ticks                            |     |
//   out     | out_valid out_ready ready_mask         | out | ready bitmap after the word
//
// a word is taken in the idle state; the slots then rotate once around the ring of
// TASK_COUNT cells through the single update unit, and the done state then loads the
// bitmap into the output register and returns to idle. words are taken only in idle, so
// a new word waits until the last word's bitmap is loaded, but a new word is taken
// while a result still waits; if the output register is still full at the end of a
// rotation the ring holds until it drains. reset marks every task ready, counters zero.
`default_nettype none

module task_delay_tick_manager_core #(
  parameter int TASK_COUNT = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                opcode,
  input  wire logic [tdtm_pkg::TASK_ID_W-1:0]      task_id,
  input  wire logic [tdtm_pkg::COUNT_W-1:0]        sleep_ticks,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [tdtm_pkg::MASK_W-1:0]              ready_mask
);

  localparam int IDX_W = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
  localparam int CMP_W = (IDX_W > tdtm_pkg::TASK_ID_W) ? IDX_W : tdtm_pkg::TASK_ID_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_COUNT - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  state_t                         state;
  logic [IDX_W-1:0]               step;
  logic                           op;
  logic [tdtm_pkg::TASK_ID_W-1:0] tid;
  logic [tdtm_pkg::COUNT_W-1:0]   ticks;

  logic                           shift;
  logic                           hit;
  logic                           out_free;
  logic [tdtm_pkg::MASK_W-1:0]    mask_next;

  tdtm_pkg::tdtm_slot_t           ring [TASK_COUNT];
  tdtm_pkg::tdtm_slot_t           head_next;

  assign in_ready = (state == S_IDLE);
  assign shift    = (state == S_RUN);
  assign out_free = !out_valid || out_ready;

  // the slot at the head belongs to task number step
  assign hit = (CMP_W'(tid) == CMP_W'(step));

  tdtm_update u_update (
    .op       (op),
    .hit      (hit),
    .ticks    (ticks),
    .slot_in  (ring[0]),
    .slot_out (head_next)
  );

  for (genvar i = 0; i < TASK_COUNT; i++) begin : g_ring
    tdtm_pkg::tdtm_slot_t feed;
    if (i == TASK_COUNT - 1) begin : g_tail
      assign feed = head_next;
    end else begin : g_mid
      assign feed = ring[i+1];
    end
    tdtm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (shift),
      .slot_in  (feed),
      .slot_out (ring[i])
    );
  end

  // tasks beyond the count read as not ready
  for (genvar b = 0; b < tdtm_pkg::MASK_W; b++) begin : g_mask
    if (b < TASK_COUNT) begin : g_have
      assign mask_next[b] = ring[b].ready;
    end else begin : g_none
      assign mask_next[b] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op    <= opcode;
            tid   <= task_id;
            ticks <= sleep_ticks;
            step  <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (step == LAST_IDX) begin
            step  <= '0;
            state <= S_DONE;
          end else begin
            step <= step + IDX_W'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            ready_mask <= mask_next;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
